### sv/q2e_pkg.sv
// shared constants, types and tables for the quaternion to euler angle converter
package q2e_pkg;

    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int QUAT_FRAC_BITS_DEF = 30;

    // working width of products, sums and cordic x/y
    localparam int WW = 72;
    // angle accumulator, 2^-30 rad
    localparam int ZW = 34;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic [15:0] SCALE_NUM = 16'd36672;
    localparam logic [33:0] SCALE_DEN = 34'd5368709120;

    localparam int PITCH_LIM = 11521;
    localparam int ANGLE_LIM = 23042;

    typedef logic signed [WW-1:0] wide_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        logic signed [14:0] pitch_deg;
        logic signed [15:0] roll_deg;
        logic signed [15:0] yaw_deg;
        logic               pitch_clamped;
    } result_t;

    function automatic ang_t atan_entry(input int i);
        ang_t r;
        r = '0;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            default: r = ang_t'(34'sd1 <<< (30 - i));
        endcase
        return r;
    endfunction

endpackage

### sv/q2e_if.sv
// valid/ready channel interfaces for quaternion items and angle results
interface q2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] q_w;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
    logic               quat_valid;
    modport source (output valid, q_w, q_x, q_y, q_z, quat_valid, input ready);
    modport sink   (input valid, q_w, q_x, q_y, q_z, quat_valid, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [15:0] yaw_deg;
    logic               pitch_clamped;
    modport source (output valid, pitch_deg, roll_deg, yaw_deg, pitch_clamped, input ready);
    modport sink   (input valid, pitch_deg, roll_deg, yaw_deg, pitch_clamped, output ready);
endinterface

### sv/q2e_cell.sv
// one cordic vectoring cell: a single micro-rotation for one angle lane
module q2e_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               en,
    input  q2e_pkg::wide_t     x,
    input  q2e_pkg::wide_t     y,
    input  q2e_pkg::ang_t      z,
    output q2e_pkg::wide_t     x_out,
    output q2e_pkg::wide_t     y_out,
    output q2e_pkg::ang_t      z_out
);
    q2e_pkg::wide_t x_reg, y_reg;
    q2e_pkg::ang_t  z_reg;
    q2e_pkg::wide_t dx, dy;
    localparam q2e_pkg::ang_t ATAN = q2e_pkg::atan_entry(IDX);

    assign dx = y >>> IDX;
    assign dy = x >>> IDX;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y[q2e_pkg::WW-1])
            begin
                x_reg <= x + dx;
                y_reg <= y - dy;
                z_reg <= z + ATAN;
            end
            else
            begin
                x_reg <= x - dx;
                y_reg <= y + dy;
                z_reg <= z - ATAN;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### sv/q2e_front.sv
// front end: products, sums, asin argument saturation and square root, pipelined
module q2e_front #(
    parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] q_w,
    input  logic signed [31:0] q_x,
    input  logic signed [31:0] q_y,
    input  logic signed [31:0] q_z,
    output q2e_pkg::wide_t     s_y,
    output q2e_pkg::wide_t     s_x,
    output q2e_pkg::wide_t     r_y,
    output q2e_pkg::wide_t     r_x,
    output q2e_pkg::wide_t     w_y,
    output q2e_pkg::wide_t     w_x,
    output logic               clamped
);
    localparam int WW = q2e_pkg::WW;
    localparam int NP = 10;
    // isqrt of a value below 2^(2F+1): result below 2^(F+1)
    localparam int RB = QUAT_FRAC_BITS + 1;
    localparam int SW = 2 * QUAT_FRAC_BITS + 2;

    typedef logic signed [63:0] prod_t;

    // stage 1: registered operands; stage 2: registered products
    logic signed [31:0] a_reg [NP];
    logic signed [31:0] b_reg [NP];
    prod_t              p_reg [NP];
    logic signed [31:0] a_next [NP];
    logic signed [31:0] b_next [NP];

    // products: wy xz yz wx xx yy xy wz ww zz
    always_comb
    begin
        a_next = '{q_w, q_x, q_y, q_w, q_x, q_y, q_x, q_w, q_w, q_z};
        b_next = '{q_y, q_z, q_z, q_x, q_x, q_y, q_y, q_z, q_w, q_z};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NP; i++)
            begin
                a_reg[i] <= a_next[i];
                b_reg[i] <= b_next[i];
                p_reg[i] <= a_reg[i] * b_reg[i];
            end
        end
    end

    q2e_pkg::wide_t m [NP];
    always_comb
    begin
        for (int i = 0; i < NP; i++)
            m[i] = WW'(p_reg[i] >>> QUAT_FRAC_BITS);
    end

    // stage 3: sums and saturation
    q2e_pkg::wide_t one;
    q2e_pkg::wide_t s_raw;
    q2e_pkg::wide_t s_reg, ry_reg, rx_reg, yy_reg, yx_reg;
    logic           cl_reg;

    assign one   = q2e_pkg::wide_t'(1) <<< QUAT_FRAC_BITS;
    assign s_raw = (m[0] - m[1]) <<< 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s_raw > one)
            begin
                s_reg  <= one;
                cl_reg <= 1'b1;
            end
            else if (s_raw < -one)
            begin
                s_reg  <= -one;
                cl_reg <= 1'b1;
            end
            else
            begin
                s_reg  <= s_raw;
                cl_reg <= 1'b0;
            end
            ry_reg <= (m[2] + m[3]) <<< 1;
            rx_reg <= one - ((m[4] + m[5]) <<< 1);
            yy_reg <= (m[6] + m[7]) <<< 1;
            yx_reg <= m[8] + m[4] - m[5] - m[9];
        end
    end

    // stage 4: |s| squared, then radicand
    logic [QUAT_FRAC_BITS:0] sa;
    logic [SW-1:0]           rad_reg;
    q2e_pkg::wide_t          s4_reg, ry4_reg, rx4_reg, yy4_reg, yx4_reg;
    logic                    cl4_reg;
    logic [SW-1:0]           one_sq;

    assign sa     = s_reg[WW-1] ? (QUAT_FRAC_BITS+1)'(-s_reg) : (QUAT_FRAC_BITS+1)'(s_reg);
    assign one_sq = SW'(1) << (2 * QUAT_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= one_sq - SW'(sa * sa);
            s4_reg  <= s_reg;
            ry4_reg <= ry_reg;
            rx4_reg <= rx_reg;
            yy4_reg <= yy_reg;
            yx4_reg <= yx_reg;
            cl4_reg <= cl_reg;
        end
    end

    // square root: one result bit per stage
    logic [SW-1:0]  rem_reg [RB+1];
    logic [RB-1:0]  root_reg [RB+1];
    q2e_pkg::wide_t sp_reg [RB+1];
    q2e_pkg::wide_t ryp_reg [RB+1];
    q2e_pkg::wide_t rxp_reg [RB+1];
    q2e_pkg::wide_t yyp_reg [RB+1];
    q2e_pkg::wide_t yxp_reg [RB+1];
    logic           clp_reg [RB+1];

    always_comb
    begin
        rem_reg[0]  = rad_reg;
        root_reg[0] = '0;
        sp_reg[0]   = s4_reg;
        ryp_reg[0]  = ry4_reg;
        rxp_reg[0]  = rx4_reg;
        yyp_reg[0]  = yy4_reg;
        yxp_reg[0]  = yx4_reg;
        clp_reg[0]  = cl4_reg;
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        localparam int B = RB - 1 - k;
        logic [SW+1:0] trial;
        assign trial = ({2'b0, SW'(root_reg[k])} << (B + 1)) + ((SW+2)'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({2'b0, rem_reg[k]} >= trial)
                begin
                    rem_reg[k+1]  <= SW'({2'b0, rem_reg[k]} - trial);
                    root_reg[k+1] <= root_reg[k] | (RB'(1) << B);
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
                sp_reg[k+1]  <= sp_reg[k];
                ryp_reg[k+1] <= ryp_reg[k];
                rxp_reg[k+1] <= rxp_reg[k];
                yyp_reg[k+1] <= yyp_reg[k];
                yxp_reg[k+1] <= yxp_reg[k];
                clp_reg[k+1] <= clp_reg[k];
            end
        end
    end

    assign s_y     = sp_reg[RB];
    assign s_x     = WW'(root_reg[RB]);
    assign r_y     = ryp_reg[RB];
    assign r_x     = rxp_reg[RB];
    assign w_y     = yyp_reg[RB];
    assign w_x     = yxp_reg[RB];
    assign clamped = clp_reg[RB];
endmodule

### sv/q2e_lane.sv
// one angle lane: quadrant pre-rotation, row of cordic cells, degree scaling
module q2e_lane #(
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int OW  = 16,
    parameter int LIM = q2e_pkg::ANGLE_LIM
) (
    input  logic                 clk,
    input  logic                 en,
    input  q2e_pkg::wide_t       y,
    input  q2e_pkg::wide_t       x,
    output logic signed [OW-1:0] deg
);
    localparam int NS = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
    localparam int WW = q2e_pkg::WW;
    localparam int ZW = q2e_pkg::ZW;

    q2e_pkg::wide_t xs [NS+1];
    q2e_pkg::wide_t ys [NS+1];
    q2e_pkg::ang_t  zs [NS+1];
    logic           zero_reg;
    logic           zero_d [NS+1];

    // pre-rotation register
    q2e_pkg::wide_t x0_reg, y0_reg;
    q2e_pkg::ang_t  z0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= (x == '0) && (y == '0);
            if (x[WW-1])
            begin
                if (!y[WW-1])
                begin
                    x0_reg <= y;
                    y0_reg <= -x;
                    z0_reg <= q2e_pkg::ANG_HALF_PI;
                end
                else
                begin
                    x0_reg <= -y;
                    y0_reg <= x;
                    z0_reg <= -q2e_pkg::ANG_HALF_PI;
                end
            end
            else
            begin
                x0_reg <= x;
                y0_reg <= y;
                z0_reg <= '0;
            end
        end
    end

    assign xs[0]     = x0_reg;
    assign ys[0]     = y0_reg;
    assign zs[0]     = z0_reg;
    assign zero_d[0] = zero_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        logic zd_reg;
        q2e_cell #(.IDX(i)) u_cell (
            .clk   (clk),
            .en    (en),
            .x     (xs[i]),
            .y     (ys[i]),
            .z     (zs[i]),
            .x_out (xs[i+1]),
            .y_out (ys[i+1]),
            .z_out (zs[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                zd_reg <= zero_d[i];
        end
        assign zero_d[i+1] = zd_reg;
    end

    // scaling: |z|*36672 registered, then rounded divide by 5*2^30
    localparam int MW = ZW + 16;
    logic [ZW-1:0] zmag;
    logic [MW-1:0] num_reg;
    logic          neg_reg;
    q2e_pkg::ang_t zf;

    assign zf   = zero_d[NS] ? '0 : zs[NS];
    assign zmag = zf[ZW-1] ? ZW'(-zf) : ZW'(zf);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= MW'(zmag) * MW'(q2e_pkg::SCALE_NUM) + MW'(q2e_pkg::SCALE_DEN >> 1);
            neg_reg <= zf[ZW-1];
        end
    end

    // divide by 5 after dropping 2^30: t / 5 via reciprocal and one correction
    localparam int TW = MW - 30;
    logic [TW-1:0] t;
    logic [TW+22:0] qe;
    logic [TW-1:0] q0, r0, q1;
    logic signed [OW:0] sq;
    logic signed [OW-1:0] deg_reg;

    assign t  = num_reg[MW-1:30];
    // 0xCCCCD / 2^22 slightly above 1/5, t is small enough for an exact floor
    assign qe = (TW+23)'(t) * (TW+23)'(23'd838861);
    assign q0 = TW'(qe >> 22);
    assign r0 = t - TW'(q0 * TW'(5));
    assign q1 = (r0 >= TW'(5)) ? q0 + TW'(1) : q0;

    always_comb
    begin
        if (q1 > TW'(LIM))
            sq = (OW+1)'(LIM);
        else
            sq = (OW+1)'(q1);
        if (neg_reg)
            sq = -sq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            deg_reg <= OW'(sq);
    end

    assign deg = deg_reg;
endmodule

### sv/quaternion_to_euler_angles_top.sv
// top level: quaternion to z-y-x euler angles converter
// Converts one quaternion item (Q2.30 by default) to pitch, roll and yaw in
// 1/128 degree units. Fully pipelined: an item is taken every cycle while the pipe
// advances, passing the bit-serial square root row and then the cordic cell row.
// The whole pipe advances only while the output register can move, so
// back-pressure holds every stage; items with quat_valid low give no result.
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES  = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    q2e_in_if.sink    in_ch,
    q2e_out_if.source out_ch
);
    localparam int NS  = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
    localparam int LAT = 4 + (QUAT_FRAC_BITS + 1) + 1 + NS + 2;

    logic en;
    logic vld_reg [LAT];

    // pipe moves when the last slot is empty or being taken
    assign en          = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_ch.valid && in_ch.quat_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    q2e_pkg::wide_t s_y, s_x, r_y, r_x, w_y, w_x;
    logic           clamped;

    q2e_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
        .clk     (clk),
        .en      (en),
        .q_w     (in_ch.q_w),
        .q_x     (in_ch.q_x),
        .q_y     (in_ch.q_y),
        .q_z     (in_ch.q_z),
        .s_y     (s_y),
        .s_x     (s_x),
        .r_y     (r_y),
        .r_x     (r_x),
        .w_y     (w_y),
        .w_x     (w_x),
        .clamped (clamped)
    );

    q2e_pkg::result_t res;

    q2e_lane #(.CORDIC_STAGES(CORDIC_STAGES), .OW(15), .LIM(q2e_pkg::PITCH_LIM)) u_pitch (
        .clk (clk), .en (en), .y (s_y), .x (s_x), .deg (res.pitch_deg)
    );
    q2e_lane #(.CORDIC_STAGES(CORDIC_STAGES), .OW(16), .LIM(q2e_pkg::ANGLE_LIM)) u_roll (
        .clk (clk), .en (en), .y (r_y), .x (r_x), .deg (res.roll_deg)
    );
    q2e_lane #(.CORDIC_STAGES(CORDIC_STAGES), .OW(16), .LIM(q2e_pkg::ANGLE_LIM)) u_yaw (
        .clk (clk), .en (en), .y (w_y), .x (w_x), .deg (res.yaw_deg)
    );

    // clamp flag rides alongside the lane
    localparam int CD = NS + 3;
    logic cl_reg [CD];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg[0] <= clamped;
            for (int i = 1; i < CD; i++)
                cl_reg[i] <= cl_reg[i-1];
        end
    end
    assign res.pitch_clamped = cl_reg[CD-1];

    assign out_ch.pitch_deg     = res.pitch_deg;
    assign out_ch.roll_deg      = res.roll_deg;
    assign out_ch.yaw_deg       = res.yaw_deg;
    assign out_ch.pitch_clamped = res.pitch_clamped;
endmodule

### bench/tb_top.sv
// self-checking bench for the quaternion to euler angle converter
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STAGES     = q2e_pkg::CORDIC_STAGES_DEF;
    localparam int    FRAC       = q2e_pkg::QUAT_FRAC_BITS_DEF;
    localparam int    LATENCY    = FRAC + STAGES + 8;
    localparam int    STALL_LIMIT = 20000;
    localparam int    N_RANDOM   = 930;
    localparam longint ONE_Q     = longint'(1) << FRAC;
    localparam longint HALF_PI_R = 1686629713;
    localparam longint DEG_NUM   = 36672;
    localparam longint DEG_DEN   = 64'sd5368709120;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               has_quat;
    } quat_item_t;

    logic clk;
    logic rst_n;
    int   n_errors;
    int   idle_cycles;
    int   burst_left;
    q2e_pkg::result_t angles_due[$];
    longint atan_steps[30];

    q2e_in_if  in_ch();
    q2e_out_if out_ch();

    quaternion_to_euler_angles_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        atan_steps = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149,
                       1048576, 524288, 262144, 131072, 65536,
                       32768, 16384, 8192, 4096, 2048,
                       1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    end

    // product of two components, floored back to the input scale
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // vectoring cordic, angle in 2^-30 rad
    function automatic longint cordic_angle(longint vy, longint vx);
        longint acc;
        longint tmp;
        longint dx;
        longint dy;
        acc = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0)
        begin
            tmp = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -tmp;
                acc = HALF_PI_R;
            end
            else
            begin
                vx = -vy;
                vy = tmp;
                acc = -HALF_PI_R;
            end
        end
        for (int i = 0; i < STAGES && i < 30; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                acc += atan_steps[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= atan_steps[i];
            end
        end
        return acc;
    endfunction

    function automatic longint to_degrees(longint ang, longint lim);
        longint num;
        longint mag;
        longint q;
        num = ang * DEG_NUM;
        mag = (num < 0) ? -num : num;
        q = (mag + DEG_DEN / 2) / DEG_DEN;
        if (num < 0)
            q = -q;
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    function automatic q2e_pkg::result_t predict_angles(quat_item_t q);
        q2e_pkg::result_t r;
        longint w, x, y, z, s, c, ry, rx, yy, yx;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        r.pitch_clamped = 1'b0;
        s = 2 * (qmul(w, y) - qmul(x, z));
        if (s > ONE_Q)
        begin
            s = ONE_Q;
            r.pitch_clamped = 1'b1;
        end
        else if (s < -ONE_Q)
        begin
            s = -ONE_Q;
            r.pitch_clamped = 1'b1;
        end
        c  = int_sqrt(longint'(ONE_Q * ONE_Q - s * s));
        ry = 2 * (qmul(y, z) + qmul(w, x));
        rx = ONE_Q - 2 * (qmul(x, x) + qmul(y, y));
        yy = 2 * (qmul(x, y) + qmul(w, z));
        yx = qmul(w, w) + qmul(x, x) - qmul(y, y) - qmul(z, z);
        r.pitch_deg = 15'(to_degrees(cordic_angle(s, c), q2e_pkg::PITCH_LIM));
        r.roll_deg  = 16'(to_degrees(cordic_angle(ry, rx), q2e_pkg::ANGLE_LIM));
        r.yaw_deg   = 16'(to_degrees(cordic_angle(yy, yx), q2e_pkg::ANGLE_LIM));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // one item, with the sender's bursts and gaps
    task automatic send_quat(quat_item_t q);
        in_ch.valid      <= 1'b1;
        in_ch.q_w        <= q.w;
        in_ch.q_x        <= q.x;
        in_ch.q_y        <= q.y;
        in_ch.q_z        <= q.z;
        in_ch.quat_valid <= q.has_quat;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (q.has_quat)
            angles_due.push_back(predict_angles(q));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_wxyz(int w, int x, int y, int z);
        quat_item_t q;
        q = '{w, x, y, z, 1'b1};
        send_quat(q);
    endtask

    function automatic logic signed [31:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return (($urandom_range(0, 1) == 1) ? 32'sd1073741824 : -32'sd1073741824);
        return $signed($urandom_range(0, 2147483647)) - 32'sd1073741824;
    endfunction

    task automatic test_directed();
        quat_item_t q;
        send_wxyz(32'sd1073741824, 0, 0, 0);
        send_wxyz(0, 0, 0, 0);
        send_wxyz(-32'sd1073741824, 0, 0, 0);
        send_wxyz(0, 32'sd1073741824, 0, 0);
        send_wxyz(0, 0, 32'sd1073741824, 0);
        send_wxyz(0, 0, 0, 32'sd1073741824);
        send_wxyz(0, -32'sd1073741824, 0, 0);
        send_wxyz(0, 0, 0, -32'sd1073741824);
        // gimbal lock, argument at and beyond one
        send_wxyz(32'sd759250125, 0, 32'sd759250125, 0);
        send_wxyz(32'sd1073741824, 0, 32'sd1073741824, 0);
        send_wxyz(32'sd1073741824, 0, -32'sd1073741824, 0);
        send_wxyz(0, 32'sd1073741824, 0, 32'sd1073741824);
        // negative x with zero y on the yaw side
        send_wxyz(0, 0, 32'sd759250125, 32'sd759250125);
        send_wxyz(32'sd536870912, 32'sd536870912, 32'sd536870912, 32'sd536870912);
        send_wxyz(-32'sd536870912, 32'sd536870912, -32'sd536870912, 32'sd536870912);
        // out of range patterns
        send_wxyz(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_wxyz(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_wxyz(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_wxyz(-1, -1, -1, -1);
        // items without a quaternion
        q = '{32'h7fffffff, 32'h80000000, 1, -1, 1'b0};
        send_quat(q);
        q = '{0, 0, 0, 0, 1'b0};
        send_quat(q);
    endtask

    task automatic test_drain_pause();
        in_ch.valid <= 1'b0;
        wait (angles_due.size() == 0);
        @(posedge clk);
    endtask

    task automatic test_random();
        quat_item_t q;
        int d;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b1};
            if ($urandom_range(0, 9) == 0)
            begin
                // near gimbal lock
                d = $urandom_range(0, 4000);
                q.w = 32'sd759250125 + d - 2000;
                q.y = (($urandom_range(0, 1) == 1) ? 32'sd759250125 : -32'sd759250125);
                q.x = $signed($urandom_range(0, 4000)) - 2000;
                q.z = $signed($urandom_range(0, 4000)) - 2000;
            end
            if ($urandom_range(0, 11) == 0)
                q.has_quat = 1'b0;
            send_quat(q);
            if (n == N_RANDOM / 2)
                test_drain_pause();
        end
    endtask

    // result checking and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        q2e_pkg::result_t want;
        int phase;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles <= 0;
            phase = 0;
        end
        else
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                if (angles_due.size() == 0)
                    report_mismatch("result count", 1, 0);
                else
                begin
                    want = angles_due.pop_front();
                    if (out_ch.pitch_deg !== want.pitch_deg)
                        report_mismatch("pitch_deg", out_ch.pitch_deg, want.pitch_deg);
                    if (out_ch.roll_deg !== want.roll_deg)
                        report_mismatch("roll_deg", out_ch.roll_deg, want.roll_deg);
                    if (out_ch.yaw_deg !== want.yaw_deg)
                        report_mismatch("yaw_deg", out_ch.yaw_deg, want.yaw_deg);
                    if (out_ch.pitch_clamped !== want.pitch_clamped)
                        report_mismatch("pitch_clamped", out_ch.pitch_clamped,
                                        want.pitch_clamped);
                end
            end
            // long open stretches, then stretches of random stalls
            phase = (phase + 1) % 400;
            if (phase < 150)
                out_ch.ready <= 1'b1;
            else if (phase < 300)
                out_ch.ready <= ($urandom_range(0, 2) != 0);
            else
                out_ch.ready <= (($urandom_range(0, 7) == 0) || (phase % 9 == 0));
        end
    end

    initial
    begin
        n_errors = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.q_w        <= '0;
        in_ch.q_x        <= '0;
        in_ch.q_y        <= '0;
        in_ch.q_z        <= '0;
        in_ch.quat_valid <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random();
        in_ch.valid <= 1'b0;
        wait (angles_due.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
sv/q2e_pkg.sv
sv/q2e_if.sv
sv/q2e_cell.sv
sv/q2e_front.sv
sv/q2e_lane.sv
sv/quaternion_to_euler_angles_top.sv
bench/tb_top.sv
